>>> rtl/core/bdo_pkg.sv
// Shared widths, codes and result types of the bounded double-ended queue.
`timescale 1ns / 1ps
package bdo_pkg;

  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 4;
  localparam int OCC_W     = 4;
  localparam int DEPTH_DEF = 8;

  localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

  // Per-item outcome handed from the pointer control to the output stage.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                rd_used;
    logic [OCC_W-1:0]    occupancy;
  } item_res_t;

endpackage

>>> rtl/core/bdo_if.sv
// Valid/ready channel interfaces for queue commands and queue results.
`timescale 1ns / 1ps
interface bdo_in_if
  import bdo_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bdo_out_if
  import bdo_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] removed_value;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output removed_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input occupancy,
                  output ready);
endinterface

>>> rtl/core/bounded_deque_overwrite_core.sv
// Top level of the bounded double-ended queue with overwrite on full.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-----------------------------------
//   in_ch    | in  | valid / ready      | kind, value
//   out_ch   | out | valid / ready      | status, removed_value, occupancy
//   cfg      | in  | cfg_we (no ready)  | cfg_wdata = capacity
//
// Each command is handled in order: the accept cycle updates head and count and
// issues the entry write or read, the next cycle loads the result register
// from the store's registered read port. The store's registered read sets this,
// and the in-flight flag holds a new command off while one is in flight.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 8;
// stored words are not cleared. A stalled result holds the next command off.
`timescale 1ns / 1ps
module bounded_deque_overwrite_core
  import bdo_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  bdo_in_if.sink           in_ch,
  bdo_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0]  cap_r;
  logic              busy_r;
  item_res_t         pend_r;
  item_res_t         res;
  logic              take;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] rdata;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_removed_r;
  logic [OCC_W-1:0]    out_occ_r;

  // Accept only with nothing in flight and the result slot free or draining,
  // so the read data always has a place to land in the following cycle.
  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;

  bdo_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .kind     (in_ch.kind),
    .capacity (cap_r),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .res      (res)
  );

  bdo_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (in_ch.value),
    .rdata (rdata)
  );

  // Control: capacity register, in-flight flag, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      busy_r <= take;
      if (busy_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold the outcome of the accepted command, then merge read data.
  always_ff @(posedge clk) begin
    if (take) begin
      pend_r <= res;
    end
    if (busy_r) begin
      out_status_r  <= pend_r.status;
      out_removed_r <= pend_r.rd_used ? rdata : '0;
      out_occ_r     <= pend_r.occupancy;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.occupancy     = out_occ_r;

endmodule

>>> rtl/core/bdo_ram.sv
// Single-port entry store with registered read.
`timescale 1ns / 1ps
module bdo_ram
  import bdo_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/bdo_ctrl.sv
// Head pointer and count of the ring, command decode and entry addressing.
`timescale 1ns / 1ps
module bdo_ctrl
  import bdo_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [KIND_W-1:0] kind,
  input  logic [CFG_W-1:0]  capacity,
  output logic              mem_we,
  output logic              mem_re,
  output logic [AW-1:0]     mem_addr,
  output item_res_t         res
);

  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int OW = (CW > OCC_W) ? CW : OCC_W;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cnt_m1;
  logic [EW-1:0] cap_e, eff_cap;
  logic [OW-1:0] occ_e;
  logic          full, empty;

  // Ring position head + offset, offset below DEPTH.
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] h,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    cap_e = EW'(capacity);
    if (capacity == '0) begin
      eff_cap = EW'(1);
    end else if (cap_e > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = cap_e;
    end
  end

  assign full   = EW'(count_r) >= eff_cap;
  assign empty  = (count_r == '0);
  assign cnt_m1 = count_r - CW'(1);

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = head_r;
    res.status  = ST_DONE;
    res.rd_used = 1'b0;
    unique case (kind_t'(kind))
      KIND_PUSH_FRONT: begin
        mem_we = take;
        if (full) begin
          res.status = ST_OVERWRITE;
        end else begin
          head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
          mem_addr  = head_nxt;
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_PUSH_BACK: begin
        mem_we = take;
        if (full) begin
          res.status = ST_OVERWRITE;
          mem_addr   = ring_pos(head_r, cnt_m1[AW-1:0]);
        end else begin
          mem_addr  = ring_pos(head_r, count_r[AW-1:0]);
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          mem_re      = take;
          res.rd_used = 1'b1;
          head_nxt    = ring_pos(head_r, AW'(1));
          count_nxt   = cnt_m1;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          mem_re      = take;
          res.rd_used = 1'b1;
          mem_addr    = ring_pos(head_r, cnt_m1[AW-1:0]);
          count_nxt   = cnt_m1;
        end
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
    occ_e         = OW'(count_nxt);
    res.occupancy = occ_e[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (take) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/core/bdo_checker.sv
// Port-level assertions for the queue core, bound to the top level.
`timescale 1ns / 1ps
module bdo_checker
  import bdo_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [DATA_W-1:0]   removed_value,
  input logic [OCC_W-1:0]    occupancy
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(removed_value) && $stable(occupancy))
    else $error("result changed while stalled");

  // Every accepted command yields a result once its registered read has landed.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result after accepted command");

  // One command in flight: no accept right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command accepted while busy");

  // Overwriting pushes and ignored pops carry no word.
  a_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_OVERWRITE || status == ST_EMPTY) |-> removed_value == '0)
    else $error("word reported without successful pop");

  // An ignored pop leaves the queue empty.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> occupancy == '0)
    else $error("empty pop with nonzero occupancy");

endmodule

bind bounded_deque_overwrite_core bdo_checker u_bdo_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .removed_value (out_ch.removed_value),
  .occupancy     (out_ch.occupancy)
);
